### src/sm4_pkg.sv
package sm4_pkg;

   localparam int ROUNDS    = 32;
   localparam int CNT_W     = $clog2(ROUNDS);
   localparam int WORD_W    = 32;
   localparam int CSR_IDX_W = 3;

   typedef logic [WORD_W-1:0]         word_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [3:0][WORD_W-1:0]    state_type;

   // register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_WORD0 = 3'd0,
      CSR_KEY_WORD1 = 3'd1,
      CSR_KEY_WORD2 = 3'd2,
      CSR_KEY_WORD3 = 3'd3
   } csr_index_type;

   // linear transform applied after the S-box
   typedef enum logic {
      MIX_DATA = 1'b0,
      MIX_KEY  = 1'b1
   } mix_sel_type;

   // control from the sequencer to the round key store
   typedef struct packed {
      logic    wr_en;
      cnt_type wr_addr;
      cnt_type rd_addr;
   } ks_ctrl_type;

   localparam word_type FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // S-box on each byte of a word
   function automatic word_type sub_word(input word_type x);
      word_type r;
      for (int j = 0; j < 4; j++) begin
         r[8*j +: 8] = SBOX[x[8*j +: 8]];
      end
      return r;
   endfunction

   // key schedule constant: byte j of CK[i] is (4i+j)*7 mod 256
   function automatic word_type ck_word(input cnt_type i);
      logic [7:0] base;
      word_type   r;
      base = {1'b0, i, 2'b00};
      for (int j = 0; j < 4; j++) begin
         r[WORD_W-1-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
      end
      return r;
   endfunction

endpackage

### src/sm4_if.sv
interface sm4_req_if;
   import sm4_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   word_type data_word0;
   word_type data_word1;
   word_type data_word2;
   word_type data_word3;
   modport source (output valid, mode, data_word0, data_word1, data_word2, data_word3,
                   input ready);
   modport sink   (input valid, mode, data_word0, data_word1, data_word2, data_word3,
                   output ready);
endinterface

interface sm4_rsp_if;
   import sm4_pkg::*;
   logic     valid;
   logic     ready;
   word_type out_word0;
   word_type out_word1;
   word_type out_word2;
   word_type out_word3;
   modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
   modport sink   (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

interface sm4_csr_if;
   import sm4_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   word_type             data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/sm4_round_unit.sv
module sm4_round_unit (
   input  sm4_pkg::state_type   x_word,
   input  sm4_pkg::word_type    round_key,
   input  sm4_pkg::mix_sel_type mix_sel,
   output sm4_pkg::word_type    next_word
);
   import sm4_pkg::*;

   word_type mix_in;
   word_type sub;
   word_type lin;

   // substitute the folded word, then diffuse with the selected transform
   assign mix_in = x_word[1] ^ x_word[2] ^ x_word[3] ^ round_key;
   assign sub    = sub_word(mix_in);

   always_comb begin
      case (mix_sel)
         MIX_KEY: lin = sub ^ {sub[WORD_W-14:0], sub[WORD_W-1 -: 13]}
                            ^ {sub[WORD_W-24:0], sub[WORD_W-1 -: 23]};
         default: lin = sub ^ {sub[WORD_W-3:0],  sub[WORD_W-1 -: 2]}
                            ^ {sub[WORD_W-11:0], sub[WORD_W-1 -: 10]}
                            ^ {sub[WORD_W-19:0], sub[WORD_W-1 -: 18]}
                            ^ {sub[WORD_W-25:0], sub[WORD_W-1 -: 24]};
      endcase
   end

   assign next_word = x_word[0] ^ lin;

endmodule

### src/sm4_key_store.sv
module sm4_key_store (
   input  logic                 clock,
   input  sm4_pkg::ks_ctrl_type ctrl,
   input  sm4_pkg::word_type    wr_data,
   output sm4_pkg::word_type    rd_data
);
   import sm4_pkg::*;

   word_type store_mem [ROUNDS];
   word_type rd_data_ff;

   // write derived round keys
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_mem[ctrl.wr_addr] <= wr_data;
      end
   end

   // registered read, passing a same-cycle write straight through
   always_ff @(posedge clock) begin
      if (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= store_mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sm4_block_cipher_core.sv
// SM4 block cipher core, 128-bit key and block. A request carries four big-endian
// data words and a mode bit (0 encrypt, 1 decrypt); the response returns the four
// final state words in reversed order. One shared round unit (S-box plus linear
// transform) runs one round per cycle; after the last round a drain state loads the
// result into the output register once that register is free. The first request after
// reset or after any key register write first runs the key schedule on the same unit.
// The block takes one request at a time; the next request is accepted as soon as the
// result sits in the output register, even while that result still waits to be taken.
// Key registers are written through the csr channel (index 0 = most significant word).
// The user writes them only while idle; the block itself does not enforce this.
module sm4_block_cipher_core (
   input  logic             clock,
   input  logic             reset,
   sm4_req_if.sink          req_bus,
   sm4_rsp_if.source        rsp_bus,
   sm4_csr_if.sink          csr_bus
);
   import sm4_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEYGEN,
      ST_ROUND,
      ST_DRAIN
   } fsm_type;

   fsm_type     state_ff,        state_in;
   cnt_type     cnt_ff,          cnt_in;
   logic        mode_ff,         mode_in;
   logic        keys_current_ff, keys_current_in;
   logic        rsp_valid_ff,    rsp_valid_in;
   state_type   key_ff,          key_in;
   state_type   x_ff,            x_in;
   state_type   buf_ff,          buf_in;
   state_type   out_ff,          out_in;

   word_type    next_word;
   word_type    rk_word;
   word_type    unit_key;
   mix_sel_type mix_sel;
   ks_ctrl_type ks_ctrl;
   logic        last_round;

   assign last_round = (cnt_ff == cnt_type'(ROUNDS - 1));
   assign mix_sel    = (state_ff == ST_KEYGEN) ? MIX_KEY : MIX_DATA;
   assign unit_key   = (state_ff == ST_KEYGEN) ? ck_word(cnt_ff) : rk_word;

   sm4_round_unit u_round (
      .x_word    (x_ff),
      .round_key (unit_key),
      .mix_sel   (mix_sel),
      .next_word (next_word)
   );

   sm4_key_store u_keys (
      .clock   (clock),
      .ctrl    (ks_ctrl),
      .wr_data (next_word),
      .rd_data (rk_word)
   );

   // sequencer next state
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      mode_in         = mode_ff;
      keys_current_in = keys_current_ff;
      rsp_valid_in    = rsp_valid_ff;
      key_in          = key_ff;
      x_in            = x_ff;
      buf_in          = buf_ff;
      out_in          = out_ff;
      ks_ctrl.wr_en   = 1'b0;
      ks_ctrl.wr_addr = cnt_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               mode_in = req_bus.mode;
               buf_in  = {req_bus.data_word3, req_bus.data_word2,
                          req_bus.data_word1, req_bus.data_word0};
               cnt_in  = '0;
               if (keys_current_ff) begin
                  x_in     = {req_bus.data_word3, req_bus.data_word2,
                              req_bus.data_word1, req_bus.data_word0};
                  state_in = ST_ROUND;
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     x_in[i] = key_ff[i] ^ FK[i];
                  end
                  state_in = ST_KEYGEN;
               end
            end
         end
         ST_KEYGEN: begin
            ks_ctrl.wr_en = 1'b1;
            x_in          = {next_word, x_ff[3], x_ff[2], x_ff[1]};
            cnt_in        = cnt_ff + cnt_type'(1);
            if (last_round) begin
               keys_current_in = 1'b1;
               x_in            = buf_ff;
               cnt_in          = '0;
               state_in        = ST_ROUND;
            end
         end
         ST_ROUND: begin
            x_in   = {next_word, x_ff[3], x_ff[2], x_ff[1]};
            cnt_in = cnt_ff + cnt_type'(1);
            if (last_round) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_in       = {x_ff[0], x_ff[1], x_ff[2], x_ff[3]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // key register writes invalidate the derived round keys
      if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_KEY_WORD0: begin
               key_in[0]       = csr_bus.data;
               keys_current_in = 1'b0;
            end
            CSR_KEY_WORD1: begin
               key_in[1]       = csr_bus.data;
               keys_current_in = 1'b0;
            end
            CSR_KEY_WORD2: begin
               key_in[2]       = csr_bus.data;
               keys_current_in = 1'b0;
            end
            CSR_KEY_WORD3: begin
               key_in[3]       = csr_bus.data;
               keys_current_in = 1'b0;
            end
            default: ;
         endcase
      end

      // prefetch the round key for the next cycle, reversed for decryption
      ks_ctrl.rd_addr = mode_in ? (cnt_type'(ROUNDS - 1) - cnt_in) : cnt_in;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         keys_current_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         key_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         keys_current_ff <= keys_current_in;
         rsp_valid_ff    <= rsp_valid_in;
         key_ff          <= key_in;
      end
      mode_ff <= mode_in;
      x_ff    <= x_in;
      buf_ff  <= buf_in;
      out_ff  <= out_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_word0 = out_ff[0];
   assign rsp_bus.out_word1 = out_ff[1];
   assign rsp_bus.out_word2 = out_ff[2];
   assign rsp_bus.out_word3 = out_ff[3];

endmodule

### src/sm4_checker.sv
module sm4_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              csr_ready,
   input sm4_pkg::word_type rsp_word0
);
   import sm4_pkg::*;

   logic req_accept;
   assign req_accept = req_valid && req_ready;

   // a waiting response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   // a stalled response keeps its first data word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word0))
      else $error("response data changed while stalled");

   // one request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("request accepted while a block is in progress");

   // no response rises at the single earlier point where the property samples an acceptance
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_accept, ROUNDS / 2))
      else $error("response too early after a request");

   // key writes are always taken
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind sm4_block_cipher_core sm4_checker u_sm4_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .csr_ready (csr_bus.ready),
   .rsp_word0 (rsp_bus.out_word0)
);

### bench/tb_sm4_block_cipher_core.sv
module tb_sm4_block_cipher_core;
   import sm4_pkg::*;

   localparam logic MODE_ENC = 1'b0;
   localparam logic MODE_DEC = 1'b1;
   localparam int   CYCLE_LIMIT = 400000;
   localparam int   HOLD_OFF_CYCLES = 250;
   localparam int   RANDOM_BLOCKS = 850;

   typedef struct packed {
      logic     mode;
      word_type w0;
      word_type w1;
      word_type w2;
      word_type w3;
   } block_req_type;

   typedef struct packed {
      word_type o0;
      word_type o1;
      word_type o2;
      word_type o3;
   } block_rsp_type;

   localparam word_type FK_TAB [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

   localparam logic [7:0] SUB_TAB [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   logic clock;
   logic reset;

   sm4_req_if req_if ();
   sm4_rsp_if rsp_if ();
   sm4_csr_if csr_if ();

   sm4_block_cipher_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // key registers and round key store as the block should hold them
   word_type key_reg [4];
   word_type rk_mem [ROUNDS];
   logic     rk_fresh = 1'b0;

   csr_index_type key_idx [4] = '{CSR_KEY_WORD0, CSR_KEY_WORD1, CSR_KEY_WORD2, CSR_KEY_WORD3};

   block_req_type plain_q [$];
   block_rsp_type out_blocks_q [$];

   int  mismatches = 0;
   int  cycle_count = 0;
   logic req_offer = 1'b0;
   int  gap_left = 0;
   int  gap_pct = 0;
   int  stall_left = 0;
   int  stall_pct = 0;
   int  hold_left = 0;
   logic hold_off_req = 1'b0;
   logic calm = 1'b0;

   function automatic word_type rotl(input word_type v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   function automatic word_type sbox_word(input word_type x);
      word_type r;
      for (int j = 0; j < 4; j++) begin
         r[8*j +: 8] = SUB_TAB[x[8*j +: 8]];
      end
      return r;
   endfunction

   function automatic word_type data_lin(input word_type x);
      word_type b;
      b = sbox_word(x);
      return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
   endfunction

   function automatic word_type key_lin(input word_type x);
      word_type b;
      b = sbox_word(x);
      return b ^ rotl(b, 13) ^ rotl(b, 23);
   endfunction

   // round constant: byte j of round i is (4i+j)*7 mod 256, first byte on top
   function automatic word_type ck_const(input int i);
      word_type c;
      c = '0;
      for (int j = 0; j < 4; j++) begin
         c = {c[23:0], 8'(((4 * i + j) * 7) & 255)};
      end
      return c;
   endfunction

   // derive the round keys from the key registers
   task automatic expand_schedule();
      word_type k [4];
      word_type n;
      for (int i = 0; i < 4; i++) begin
         k[i] = key_reg[i] ^ FK_TAB[i];
      end
      for (int r = 0; r < ROUNDS; r++) begin
         n = k[0] ^ key_lin(k[1] ^ k[2] ^ k[3] ^ ck_const(r));
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = n;
         rk_mem[r] = n;
      end
      rk_fresh = 1'b1;
   endtask

   // run all rounds over one block; decryption walks the round keys backwards
   function automatic block_rsp_type sm4_crypt(input block_req_type blk);
      word_type      x [4];
      word_type      rk;
      word_type      n;
      block_rsp_type res;
      x[0] = blk.w0;
      x[1] = blk.w1;
      x[2] = blk.w2;
      x[3] = blk.w3;
      for (int r = 0; r < ROUNDS; r++) begin
         rk = (blk.mode == MODE_DEC) ? rk_mem[ROUNDS-1-r] : rk_mem[r];
         n = x[0] ^ data_lin(x[1] ^ x[2] ^ x[3] ^ rk);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = n;
      end
      res.o0 = x[3];
      res.o1 = x[2];
      res.o2 = x[1];
      res.o3 = x[0];
      return res;
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WORD_W - 1);
         default: return $urandom();
      endcase
   endfunction

   task automatic push_block(input logic mode, input word_type w0, input word_type w1,
                             input word_type w2, input word_type w3);
      block_req_type blk;
      blk.mode = mode;
      blk.w0 = w0;
      blk.w1 = w1;
      blk.w2 = w2;
      blk.w3 = w3;
      plain_q.push_back(blk);
   endtask

   // one register write; the key copy follows at the handshake
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input word_type val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!(csr_if.valid && csr_if.ready)) @(posedge clock);
      if (idx <= CSR_KEY_WORD3) begin
         key_reg[idx[1:0]] = val;
         rk_fresh = 1'b0;
      end
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic write_key(input word_type k0, input word_type k1, input word_type k2,
                            input word_type k3);
      write_csr(key_idx[0], k0);
      write_csr(key_idx[1], k1);
      write_csr(key_idx[2], k2);
      write_csr(key_idx[3], k3);
   endtask

   // wait until every queued block has gone through and come back
   task automatic drain();
      while (plain_q.size() != 0 || out_blocks_q.size() != 0 || req_offer) @(posedge clock);
   endtask

   task automatic check_word(input string fld, input word_type want, input word_type got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // drive requests from the pending queue, with random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_offer) begin
         // hold the current request until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_if.valid <= 1'b0;
      end else if (plain_q.size() != 0) begin
         req_if.valid      <= 1'b1;
         req_if.mode       <= plain_q[0].mode;
         req_if.data_word0 <= plain_q[0].w0;
         req_if.data_word1 <= plain_q[0].w1;
         req_if.data_word2 <= plain_q[0].w2;
         req_if.data_word3 <= plain_q[0].w3;
         req_offer = 1'b1;
         if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap_left = $urandom_range(1, 13);
         end
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // take each accepted request and predict its response
   always @(posedge clock) begin : take_request
      block_req_type blk;
      if (!reset && req_if.valid && req_if.ready) begin
         blk.mode = req_if.mode;
         blk.w0 = req_if.data_word0;
         blk.w1 = req_if.data_word1;
         blk.w2 = req_if.data_word2;
         blk.w3 = req_if.data_word3;
         if (!rk_fresh) begin
            expand_schedule();
         end
         out_blocks_q.push_back(sm4_crypt(blk));
         void'(plain_q.pop_front());
         req_offer = 1'b0;
      end
   end

   // response ready: always high when calm, one long hold-off on request, otherwise random stall bursts
   always @(negedge clock) begin
      if (calm) begin
         rsp_if.ready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 13);
         end
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin : check_response
      block_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (out_blocks_q.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected, actual %h %h %h %h", $time,
                     rsp_if.out_word0, rsp_if.out_word1, rsp_if.out_word2, rsp_if.out_word3);
         end else begin
            want = out_blocks_q.pop_front();
            check_word("out_word0", want.o0, rsp_if.out_word0);
            check_word("out_word1", want.o1, rsp_if.out_word1);
            check_word("out_word2", want.o2, rsp_if.out_word2);
            check_word("out_word3", want.o3, rsp_if.out_word3);
         end
      end
   end

   initial begin : stimulus
      int random_total;
      int phase;
      int n;
      random_total = 0;
      phase = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.mode = MODE_ENC;
      req_if.data_word0 = '0;
      req_if.data_word1 = '0;
      req_if.data_word2 = '0;
      req_if.data_word3 = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      for (int i = 0; i < 4; i++) begin
         key_reg[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // blocks under the reset key, schedule derived on the first one
      gap_pct = 20;
      stall_pct = 20;
      push_block(MODE_ENC, '0, '0, '0, '0);
      push_block(MODE_DEC, '0, '0, '0, '0);
      push_block(MODE_ENC, '1, '1, '1, '1);
      drain();

      // standard key with its known vector, then field extremes and both modes
      write_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      push_block(MODE_ENC, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      push_block(MODE_DEC, 32'h681edf34, 32'hd206965e, 32'h86b3e94f, 32'h536e4246);
      push_block(MODE_ENC, '0, '0, '0, '0);
      push_block(MODE_ENC, '1, '1, '1, '1);
      push_block(MODE_DEC, '1, '1, '1, '1);
      push_block(MODE_ENC, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
      push_block(MODE_DEC, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
      push_block(MODE_ENC, 32'h80000000, '0, '0, '0);
      push_block(MODE_DEC, '0, '0, '0, 32'h00000001);
      push_block(MODE_ENC, $urandom(), $urandom(), $urandom(), $urandom());
      push_block(MODE_DEC, $urandom(), $urandom(), $urandom(), $urandom());
      drain();

      // a single key word changed forces a fresh schedule
      write_csr(CSR_KEY_WORD3, '1);
      push_block(MODE_ENC, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      push_block(MODE_DEC, 32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      drain();

      // writes past the key registers must leave the key alone
      for (int i = 4; i < 8; i++) begin
         write_csr(CSR_IDX_W'(i), $urandom());
      end
      push_block(MODE_ENC, 32'hdeadbeef, 32'h00000000, 32'hffffffff, 32'h12345678);
      push_block(MODE_DEC, 32'hdeadbeef, 32'h00000000, 32'hffffffff, 32'h12345678);
      drain();

      // random phases, each under its own key and idling mix
      while (random_total < RANDOM_BLOCKS) begin
         case (phase % 5)
            0: write_key('0, '0, '0, '0);
            1: write_key('1, '1, '1, '1);
            2: write_key($urandom(), $urandom(), $urandom(), $urandom());
            3: write_csr(key_idx[$urandom_range(0, 3)], rand_word());
            default: write_key(rand_word(), rand_word(), rand_word(), rand_word());
         endcase
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_IDX_W'($urandom_range(4, 7)), $urandom());
         end
         case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 10;
            2: gap_pct = 30;
            default: gap_pct = 60;
         endcase
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 30;
            default: stall_pct = 60;
         endcase
         if (phase == 2) begin
            hold_off_req = 1'b1;
         end
         // no idling at all in the closing stretch
         if (random_total >= RANDOM_BLOCKS - 120) begin
            calm = 1'b1;
            gap_left = 0;
         end
         n = $urandom_range(50, 90);
         for (int i = 0; i < n; i++) begin
            push_block(logic'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
                       rand_word());
         end
         drain();
         random_total += n;
         phase++;
      end

      // let any stray response show up before the verdict
      repeat (80) @(posedge clock);
      if (mismatches == 0 && out_blocks_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
